FILE: src/ums2cd_pkg.sv
`timescale 1ns / 1ps

package ums2cd_pkg;

  localparam int unsigned TS_W   = 48;  // input timestamp width
  localparam int unsigned REM_W  = 27;  // divider remainder width
  localparam int unsigned DAYS_W = 22;  // whole days, also the walk register
  localparam int unsigned YEAR_W = 14;
  localparam int unsigned CNT_W  = 6;

  // Divider passes, each one restoring bit-serial division by a constant
  typedef enum logic [1:0] {
    PH_DAY = 2'd0,  // ms / 86400000
    PH_SEC = 2'd1,  // ms of day / 1000
    PH_MIN = 2'd2,  // seconds of day / 60
    PH_HR  = 2'd3   // minutes of day / 60
  } div_phase_t;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_DIV  = 8'b0000_0010,
    ST_ERA  = 8'b0000_0100,
    ST_CENT = 8'b0000_1000,
    ST_BLK  = 8'b0001_0000,
    ST_YR   = 8'b0010_0000,
    ST_MON  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_t;

  // Days from 0000-03-01 (proleptic Gregorian) to 1970-01-01
  localparam logic [DAYS_W-1:0] EPOCH_SHIFT  = 22'd719468;
  localparam logic [DAYS_W-1:0] DAYS_ERA     = 22'd146097;
  localparam logic [DAYS_W-1:0] DAYS_CENTURY = 22'd36524;
  localparam logic [DAYS_W-1:0] DAYS_QUAD    = 22'd1461;
  localparam logic [DAYS_W-1:0] DAYS_YEAR    = 22'd365;

  localparam logic [YEAR_W-1:0] YEARS_ERA     = 14'd400;
  localparam logic [YEAR_W-1:0] YEARS_CENTURY = 14'd100;
  localparam logic [YEAR_W-1:0] YEARS_QUAD    = 14'd4;

  localparam logic [CNT_W-1:0] CENT_MAX = 6'd3;
  localparam logic [CNT_W-1:0] QUAD_MAX = 6'd24;
  localparam logic [CNT_W-1:0] YEAR_MAX = 6'd3;
  localparam logic [CNT_W-1:0] MON_MAX  = 6'd11;

  function automatic logic [REM_W-1:0] divisor(input div_phase_t ph);
    logic [REM_W-1:0] d;
    unique case (ph)
      PH_DAY:  d = 27'd86400000;
      PH_SEC:  d = 27'd1000;
      PH_MIN:  d = 27'd60;
      PH_HR:   d = 27'd60;
      default: d = 27'd60;
    endcase
    return d;
  endfunction

  // Last step index of each pass (dividend width minus one)
  function automatic logic [CNT_W-1:0] last_step(input div_phase_t ph);
    logic [CNT_W-1:0] n;
    unique case (ph)
      PH_DAY:  n = 6'd47;
      PH_SEC:  n = 6'd26;
      PH_MIN:  n = 6'd16;
      PH_HR:   n = 6'd10;
      default: n = 6'd10;
    endcase
    return n;
  endfunction

  // Month lengths with the year starting in March; February last
  function automatic logic [4:0] mar_month_len(input logic [3:0] mp);
    logic [4:0] len;
    case (mp) inside
      4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10: len = 5'd31;
      4'd11:   len = 5'd29;
      default: len = 5'd30;
    endcase
    return len;
  endfunction

endpackage

FILE: src/unix_ms_to_calendar_date_core.sv
`timescale 1ns / 1ps

// Unix millisecond time to Gregorian date and UTC time of day. One 48-bit
// item in, one result out (year, month, day_of_month, hour, minute, second);
// milliseconds are dropped. A single restoring divider works one quotient bit
// per cycle through four passes: ms/86400000, ms-of-day/1000, seconds/60 and
// minutes/60. The day count is then rebased to a March-based calendar and
// walked off by one subtract per cycle in strides of 400 years (up to 27),
// 100 years (up to 3), 4 years (up to 24), 1 year (up to 3) and months (up
// to 11). One item is in flight at a time; in_ready is high only when the
// block is idle. The result sits in an output register, so a new item can be
// taken while it waits.
module unix_ms_to_calendar_date_core
  import ums2cd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_timestamp_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [13:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_second
);

  state_t            state_r, state_nxt;
  div_phase_t        phase_r, phase_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TS_W-1:0]   num_r, num_nxt;     // dividend in, quotient out
  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [DAYS_W-1:0] days_r, days_nxt;   // whole days, then walk remainder
  logic [YEAR_W-1:0] year_r, year_nxt;
  logic [5:0]        sec_r, sec_nxt;
  logic [5:0]        min_r, min_nxt;
  logic [4:0]        hr_r, hr_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [13:0]       o_year_r, o_year_nxt;
  logic [3:0]        o_month_r, o_month_nxt;
  logic [4:0]        o_day_r, o_day_nxt;
  logic [4:0]        o_hour_r, o_hour_nxt;
  logic [5:0]        o_min_r, o_min_nxt;
  logic [5:0]        o_sec_r, o_sec_nxt;

  // divider step
  logic [REM_W:0]    rem_sh;
  logic [REM_W:0]    dvs;
  logic              q_bit;
  logic [REM_W-1:0]  rem_step;
  logic [TS_W-1:0]   quo;

  // walk step
  logic [DAYS_W-1:0] stride;
  logic [YEAR_W-1:0] yr_add;
  logic [CNT_W-1:0]  limit;
  logic              take;
  logic [DAYS_W-1:0] walk_sub;
  logic              slot_free;

  assign rem_sh   = {rem_r, num_r[TS_W-1]};
  assign dvs      = {1'b0, divisor(phase_r)};
  assign q_bit    = (rem_sh >= dvs);
  assign rem_step = q_bit ? REM_W'(rem_sh - dvs) : rem_sh[REM_W-1:0];
  assign quo      = {num_r[TS_W-2:0], q_bit};

  // stride and step limit of the current walk level
  always_comb begin
    stride = DAYS_YEAR;
    yr_add = 14'd1;
    limit  = YEAR_MAX;
    case (state_r)
      ST_ERA: begin
        stride = DAYS_ERA;
        yr_add = YEARS_ERA;
        limit  = {CNT_W{1'b1}};
      end
      ST_CENT: begin
        stride = DAYS_CENTURY;
        yr_add = YEARS_CENTURY;
        limit  = CENT_MAX;
      end
      ST_BLK: begin
        stride = DAYS_QUAD;
        yr_add = YEARS_QUAD;
        limit  = QUAD_MAX;
      end
      ST_MON: begin
        stride = {{(DAYS_W-5){1'b0}}, mar_month_len(cnt_r[3:0])};
        yr_add = '0;
        limit  = MON_MAX;
      end
      default: ;
    endcase
  end

  // era count is unbounded by the counter; it is limited by the day range
  assign take      = (days_r >= stride) &&
                     ((state_r == ST_ERA) || (cnt_r < limit));
  assign walk_sub  = days_r - stride;
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cnt_nxt       = cnt_r;
    num_nxt       = num_r;
    rem_nxt       = rem_r;
    days_nxt      = days_r;
    year_nxt      = year_r;
    sec_nxt       = sec_r;
    min_nxt       = min_r;
    hr_nxt        = hr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_year_nxt    = o_year_r;
    o_month_nxt   = o_month_r;
    o_day_nxt     = o_day_r;
    o_hour_nxt    = o_hour_r;
    o_min_nxt     = o_min_r;
    o_sec_nxt     = o_sec_r;

    unique case (state_r) inside
      ST_IDLE: begin
        if (in_valid) begin
          num_nxt   = in_timestamp_ms;
          rem_nxt   = '0;
          phase_nxt = PH_DAY;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_DIV: begin
        num_nxt = quo;
        rem_nxt = rem_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == last_step(phase_r)) begin
          cnt_nxt = '0;
          rem_nxt = '0;
          case (phase_r)
            PH_DAY: begin
              days_nxt  = quo[DAYS_W-1:0];
              num_nxt   = {rem_step, {(TS_W-REM_W){1'b0}}};
              phase_nxt = PH_SEC;
            end
            PH_SEC: begin
              num_nxt   = {quo[16:0], {(TS_W-17){1'b0}}};
              phase_nxt = PH_MIN;
            end
            PH_MIN: begin
              sec_nxt   = rem_step[5:0];
              num_nxt   = {quo[10:0], {(TS_W-11){1'b0}}};
              phase_nxt = PH_HR;
            end
            default: begin
              min_nxt   = rem_step[5:0];
              hr_nxt    = quo[4:0];
              days_nxt  = days_r + EPOCH_SHIFT;
              year_nxt  = '0;
              state_nxt = ST_ERA;
            end
          endcase
        end
      end

      ST_ERA, ST_CENT, ST_BLK, ST_YR: begin
        if (take) begin
          days_nxt = walk_sub;
          year_nxt = year_r + yr_add;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          cnt_nxt = '0;
          case (state_r)
            ST_ERA:  state_nxt = ST_CENT;
            ST_CENT: state_nxt = ST_BLK;
            ST_BLK:  state_nxt = ST_YR;
            default: state_nxt = ST_MON;
          endcase
        end
      end

      ST_MON: begin
        if (take) begin
          days_nxt = walk_sub;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_DONE: begin
        // cnt holds the March-based month; January and February close the year
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_year_nxt    = year_r + {13'd0, (cnt_r >= 6'd10)};
          o_month_nxt   = (cnt_r >= 6'd10) ? 4'(cnt_r - 6'd9) : 4'(cnt_r + 6'd3);
          o_day_nxt     = 5'(days_r + 1'b1);
          o_hour_nxt    = hr_r;
          o_min_nxt     = min_r;
          o_sec_nxt     = sec_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r   <= phase_nxt;
    cnt_r     <= cnt_nxt;
    num_r     <= num_nxt;
    rem_r     <= rem_nxt;
    days_r    <= days_nxt;
    year_r    <= year_nxt;
    sec_r     <= sec_nxt;
    min_r     <= min_nxt;
    hr_r      <= hr_nxt;
    o_year_r  <= o_year_nxt;
    o_month_r <= o_month_nxt;
    o_day_r   <= o_day_nxt;
    o_hour_r  <= o_hour_nxt;
    o_min_r   <= o_min_nxt;
    o_sec_r   <= o_sec_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_year         = o_year_r;
  assign out_month        = o_month_r;
  assign out_day_of_month = o_day_r;
  assign out_hour         = o_hour_r;
  assign out_minute       = o_min_r;
  assign out_second       = o_sec_r;

endmodule
